// ===== rtl/core/rgd_pkg.sv =====
package rgd_pkg;

   localparam int INDEX_WIDTH = 10;
   localparam int VALUE_PORT_WIDTH = 32;
   localparam int RESULT_WIDTH = 32;
   localparam int MODE_WIDTH = 2;

   localparam logic [MODE_WIDTH-1:0] MODE_CLEAR  = 2'd0;
   localparam logic [MODE_WIDTH-1:0] MODE_APPEND = 2'd1;
   localparam logic [MODE_WIDTH-1:0] MODE_QUERY  = 2'd2;
   localparam logic [MODE_WIDTH-1:0] MODE_UNUSED = 2'd3;

   typedef struct packed {
      logic take;
      logic wr_diff;
      logic rd_first;
      logic rd_second;
      logic load_acc;
      logic gcd_start;
      logic wr_gcd;
      logic acc_gcd;
      logic q_step;
      logic commit;
      logic rsp_load;
   } cmd_type;

   typedef struct packed {
      logic full;
      logic empty;
      logic simple;
      logic lvl_more;
      logic q_win;
      logic q_tail;
      logic gcd_busy;
   } sts_type;

endpackage

// ===== rtl/core/rgd_ram.sv =====
module rgd_ram #(
   parameter int WIDTH = 32,
   parameter int WORDS = 1024
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(WORDS)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic [$clog2(WORDS)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [WORDS];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem_ff[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

// ===== rtl/core/rgd_gcd.sv =====
module rgd_gcd #(
   parameter int W = 32
) (
   input  logic         clock,
   input  logic         reset,
   input  logic         start,
   input  logic [W-1:0] opa,
   input  logic [W-1:0] opb,
   output logic         busy,
   output logic [W-1:0] result
);

   localparam int KW = $clog2(W + 1);

   logic [W-1:0]  a_ff;
   logic [W-1:0]  b_ff;
   logic [KW-1:0] k_ff;
   logic          busy_ff;
   logic [W-1:0]  res_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
      end else if (start) begin
         a_ff    <= opa;
         b_ff    <= opb;
         k_ff    <= '0;
         busy_ff <= 1'b1;
      end else if (busy_ff) begin
         if (a_ff == '0 || b_ff == '0) begin
            res_ff  <= (a_ff | b_ff) << k_ff;
            busy_ff <= 1'b0;
         end else if (!a_ff[0] && !b_ff[0]) begin
            a_ff <= a_ff >> 1;
            b_ff <= b_ff >> 1;
            k_ff <= k_ff + 1'b1;
         end else if (!a_ff[0]) begin
            a_ff <= a_ff >> 1;
         end else if (!b_ff[0]) begin
            b_ff <= b_ff >> 1;
         end else if (a_ff >= b_ff) begin
            a_ff <= a_ff - b_ff;
         end else begin
            b_ff <= b_ff - a_ff;
         end
      end
   end

   assign busy   = busy_ff;
   assign result = res_ff;

endmodule

// ===== rtl/core/rgd_datapath.sv =====
module rgd_datapath
   import rgd_pkg::*;
#(
   parameter int DEPTH = 1024,
   parameter int VALUE_WIDTH = 32,
   parameter int LEVELS = 11
) (
   input  logic                        clock,
   input  logic                        reset,
   input  logic [MODE_WIDTH-1:0]       req_mode,
   input  logic [VALUE_PORT_WIDTH-1:0] req_value,
   input  logic [INDEX_WIDTH-1:0]      req_left_index,
   input  logic [INDEX_WIDTH-1:0]      req_right_index,
   input  cmd_type                     cmd,
   output sts_type                     sts,
   output logic [RESULT_WIDTH-1:0]     rsp_range_gcd,
   output logic                        rsp_bad_range
);

   localparam int VW  = VALUE_WIDTH;
   localparam int PW  = $clog2(DEPTH);
   localparam int CW  = $clog2(DEPTH + 1);
   localparam int LW  = $clog2(LEVELS + 1);
   localparam int LAW = (LEVELS > 1) ? $clog2(LEVELS) : 1;
   localparam int RAW = LAW + PW;
   localparam int MW  = (PW > INDEX_WIDTH) ? PW : INDEX_WIDTH;
   localparam int AW  = ((MW > LEVELS) ? MW : LEVELS) + 1;
   localparam int XW  = (VW > VALUE_PORT_WIDTH) ? VW : VALUE_PORT_WIDTH;
   localparam int YW  = (VW > RESULT_WIDTH) ? VW : RESULT_WIDTH;

   function automatic logic [LW-1:0] q_level(input logic [INDEX_WIDTH-1:0] len);
      int r;
      r = 0;
      for (int i = 0; i < INDEX_WIDTH; i++) begin
         if (len[i]) begin
            r = i;
         end
      end
      if (r > LEVELS - 1) begin
         r = LEVELS - 1;
      end
      return LW'(r);
   endfunction

   logic [VW-1:0]           prev_ff;
   logic [CW-1:0]           count_ff;
   logic [VW-1:0]           val_ff;
   logic [AW-1:0]           pos_ff;
   logic [AW-1:0]           end_ff;
   logic [LW-1:0]           level_ff;
   logic [VW-1:0]           acc_ff;
   logic                    bad_ff;
   logic [RESULT_WIDTH-1:0] rsp_gcd_ff;
   logic                    rsp_bad_ff;

   logic [XW-1:0]           value_x;
   logic [VW-1:0]           value_c;
   logic [AW-1:0]           count_x;
   logic [AW-1:0]           span;
   logic [AW-1:0]           half;
   logic [AW-1:0]           start;
   logic [AW-1:0]           dpos;
   logic [LW-1:0]           lvlm1;
   logic                    bad_c;
   logic [VW-1:0]           abs_diff;
   logic [YW-1:0]           acc_x;
   logic                    wr_en;
   logic [RAW-1:0]          wr_addr;
   logic [VW-1:0]           wr_data;
   logic [RAW-1:0]          rd_addr;
   logic [VW-1:0]           rd_data;
   logic                    gcd_busy;
   logic [VW-1:0]           gcd_res;

   assign value_x  = XW'(req_value);
   assign value_c  = value_x[VW-1:0];
   assign count_x  = AW'(count_ff);
   assign span     = AW'(1) << level_ff;
   assign half     = span >> 1;
   assign start    = count_x - span;
   assign dpos     = count_x - AW'(1);
   assign lvlm1    = level_ff - 1'b1;
   assign bad_c    = (req_right_index < req_left_index) ||
                     (AW'(req_right_index) >= count_x);
   assign abs_diff = (val_ff > prev_ff) ? val_ff - prev_ff : prev_ff - val_ff;

   assign sts.full     = (count_ff == CW'(DEPTH));
   assign sts.empty    = (count_ff == '0);
   assign sts.simple   = bad_c || (req_left_index == req_right_index);
   assign sts.lvl_more = (level_ff < LW'(LEVELS)) && (count_x >= span);
   assign sts.q_win    = (pos_ff + span) <= end_ff;
   assign sts.q_tail   = pos_ff < end_ff;
   assign sts.gcd_busy = gcd_busy;

   assign wr_en   = cmd.wr_diff || cmd.wr_gcd;
   assign wr_data = cmd.wr_diff ? abs_diff : gcd_res;
   assign wr_addr = cmd.wr_diff ? {LAW'(0), dpos[PW-1:0]}
                                : {level_ff[LAW-1:0], start[PW-1:0]};

   always_comb begin
      if (cmd.rd_first) begin
         rd_addr = {lvlm1[LAW-1:0], start[PW-1:0]};
      end else if (cmd.rd_second) begin
         rd_addr = {lvlm1[LAW-1:0], start[PW-1:0] + half[PW-1:0]};
      end else if (sts.q_win) begin
         rd_addr = {level_ff[LAW-1:0], pos_ff[PW-1:0]};
      end else begin
         rd_addr = {level_ff[LAW-1:0], end_ff[PW-1:0] - span[PW-1:0]};
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         prev_ff  <= '0;
         count_ff <= '0;
      end else begin
         if (cmd.take) begin
            case (req_mode)
               MODE_CLEAR: begin
                  prev_ff  <= '0;
                  count_ff <= '0;
               end
               MODE_APPEND: begin
                  val_ff   <= value_c;
                  level_ff <= LW'(1);
                  if (count_ff == '0) begin
                     prev_ff  <= value_c;
                     count_ff <= CW'(1);
                  end
               end
               MODE_QUERY: begin
                  acc_ff   <= '0;
                  bad_ff   <= bad_c;
                  pos_ff   <= AW'(req_left_index);
                  end_ff   <= AW'(req_right_index);
                  level_ff <= q_level(req_right_index - req_left_index);
               end
               default: begin
               end
            endcase
         end
         if (cmd.load_acc) begin
            acc_ff <= rd_data;
         end
         if (cmd.acc_gcd) begin
            acc_ff <= gcd_res;
         end
         if (cmd.wr_gcd) begin
            level_ff <= level_ff + 1'b1;
         end
         if (cmd.q_step) begin
            pos_ff <= sts.q_win ? pos_ff + span : end_ff;
         end
         if (cmd.commit) begin
            prev_ff  <= val_ff;
            count_ff <= count_ff + 1'b1;
         end
      end
   end

   assign acc_x = YW'(acc_ff);

   always_ff @(posedge clock) begin
      if (cmd.rsp_load) begin
         rsp_gcd_ff <= acc_x[RESULT_WIDTH-1:0];
         rsp_bad_ff <= bad_ff;
      end
   end

   assign rsp_range_gcd = rsp_gcd_ff;
   assign rsp_bad_range = rsp_bad_ff;

   rgd_ram #(
      .WIDTH (VW),
      .WORDS (1 << RAW)
   ) u_table (
      .clock   (clock),
      .wr_en   (wr_en),
      .wr_addr (wr_addr),
      .wr_data (wr_data),
      .rd_addr (rd_addr),
      .rd_data (rd_data)
   );

   rgd_gcd #(
      .W (VW)
   ) u_gcd (
      .clock  (clock),
      .reset  (reset),
      .start  (cmd.gcd_start),
      .opa    (acc_ff),
      .opb    (rd_data),
      .busy   (gcd_busy),
      .result (gcd_res)
   );

endmodule

// ===== rtl/core/rgd_ctrl.sv =====
module rgd_ctrl
   import rgd_pkg::*;
(
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_valid,
   input  logic [MODE_WIDTH-1:0] req_mode,
   output logic                  req_ready,
   output logic                  rsp_valid,
   input  logic                  rsp_ready,
   input  sts_type               sts,
   output cmd_type               cmd
);

   localparam logic [3:0] S_IDLE  = 4'd0;
   localparam logic [3:0] S_AWR0  = 4'd1;
   localparam logic [3:0] S_ACHK  = 4'd2;
   localparam logic [3:0] S_ARDB  = 4'd3;
   localparam logic [3:0] S_AGS   = 4'd4;
   localparam logic [3:0] S_AWAIT = 4'd5;
   localparam logic [3:0] S_QCHK  = 4'd6;
   localparam logic [3:0] S_QGS   = 4'd7;
   localparam logic [3:0] S_QWAIT = 4'd8;
   localparam logic [3:0] S_OUT   = 4'd9;

   logic [3:0] state_ff;
   logic [3:0] state_in;
   logic       rsp_valid_ff;
   logic       rsp_valid_in;

   always_comb begin
      state_in  = state_ff;
      cmd       = '0;
      req_ready = 1'b0;
      case (state_ff)
         S_IDLE: begin
            req_ready = 1'b1;
            if (req_valid) begin
               cmd.take = 1'b1;
               if (req_mode == MODE_APPEND && !sts.full && !sts.empty) begin
                  state_in = S_AWR0;
               end else if (req_mode == MODE_QUERY) begin
                  state_in = sts.simple ? S_OUT : S_QCHK;
               end
            end
         end
         S_AWR0: begin
            cmd.wr_diff = 1'b1;
            state_in    = S_ACHK;
         end
         S_ACHK: begin
            if (sts.lvl_more) begin
               cmd.rd_first = 1'b1;
               state_in     = S_ARDB;
            end else begin
               cmd.commit = 1'b1;
               state_in   = S_IDLE;
            end
         end
         S_ARDB: begin
            cmd.rd_second = 1'b1;
            cmd.load_acc  = 1'b1;
            state_in      = S_AGS;
         end
         S_AGS: begin
            cmd.gcd_start = 1'b1;
            state_in      = S_AWAIT;
         end
         S_AWAIT: begin
            if (!sts.gcd_busy) begin
               cmd.wr_gcd = 1'b1;
               state_in   = S_ACHK;
            end
         end
         S_QCHK: begin
            if (sts.q_win || sts.q_tail) begin
               cmd.q_step = 1'b1;
               state_in   = S_QGS;
            end else begin
               state_in = S_OUT;
            end
         end
         S_QGS: begin
            cmd.gcd_start = 1'b1;
            state_in      = S_QWAIT;
         end
         S_QWAIT: begin
            if (!sts.gcd_busy) begin
               cmd.acc_gcd = 1'b1;
               state_in    = S_QCHK;
            end
         end
         S_OUT: begin
            if (!rsp_valid_ff || rsp_ready) begin
               cmd.rsp_load = 1'b1;
               state_in     = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      if (cmd.rsp_load) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_ready) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   assign rsp_valid = rsp_valid_ff;

endmodule

// ===== rtl/core/range_gcd_of_differences.sv =====
// Range GCD of adjacent differences over a sequence loaded one element at a time.
// Request channel (req_valid/req_ready): req_mode selects clear, append or range
// query; req_value carries the appended element, req_left_index and
// req_right_index the inclusive query range. Only a query returns a transfer on the
// response channel (rsp_valid/rsp_ready): rsp_range_gcd and rsp_bad_range.
// One request is processed at a time, through a single iterative binary GCD unit
// and a table memory with one registered read port.
// Clear and mode three are completed as they are accepted. An append writes its
// difference to the table and, for each table level it extends, reads two cells of
// the level below and writes their GCD; a query reads up to two windows of its
// table level, one GCD each, more when the range exceeds the top table level.
// Reset empties the sequence and clears the response valid flag; the table is not
// cleared, as only entries written by the current sequence are ever read.
// A finished response is held in an output register, so the next request is
// accepted while it waits; a further query result is held back until the
// receiver takes the pending transfer.
module range_gcd_of_differences
   import rgd_pkg::*;
#(
   parameter int DEPTH = 1024,
   parameter int VALUE_WIDTH = 32,
   parameter int LEVELS = 11
) (
   input  logic                        clock,
   input  logic                        reset,
   input  logic                        req_valid,
   output logic                        req_ready,
   input  logic [MODE_WIDTH-1:0]       req_mode,
   input  logic [VALUE_PORT_WIDTH-1:0] req_value,
   input  logic [INDEX_WIDTH-1:0]      req_left_index,
   input  logic [INDEX_WIDTH-1:0]      req_right_index,
   output logic                        rsp_valid,
   input  logic                        rsp_ready,
   output logic [RESULT_WIDTH-1:0]     rsp_range_gcd,
   output logic                        rsp_bad_range
);

   cmd_type cmd;
   sts_type sts;

   rgd_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_mode  (req_mode),
      .req_ready (req_ready),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .sts       (sts),
      .cmd       (cmd)
   );

   rgd_datapath #(
      .DEPTH       (DEPTH),
      .VALUE_WIDTH (VALUE_WIDTH),
      .LEVELS      (LEVELS)
   ) u_datapath (
      .clock           (clock),
      .reset           (reset),
      .req_mode        (req_mode),
      .req_value       (req_value),
      .req_left_index  (req_left_index),
      .req_right_index (req_right_index),
      .cmd             (cmd),
      .sts             (sts),
      .rsp_range_gcd   (rsp_range_gcd),
      .rsp_bad_range   (rsp_bad_range)
   );

endmodule

// ===== rtl/core/rgd_checker.sv =====
module rgd_checker
   import rgd_pkg::*;
(
   input logic                    clock,
   input logic                    reset,
   input logic                    req_ready,
   input logic                    rsp_valid,
   input logic                    rsp_ready,
   input logic [RESULT_WIDTH-1:0] rsp_range_gcd,
   input logic                    rsp_bad_range
);

   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_range_gcd) &&
                                  $stable(rsp_bad_range))
      else $error("Response transfer changed while stalled.");

   a_bad_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_bad_range |-> rsp_range_gcd == '0)
      else $error("Rejected range returned a non-zero GCD.");

   a_reset_idle: assert property (@(posedge clock)
      $past(reset) |-> !rsp_valid)
      else $error("Response valid straight after reset.");

   a_busy_before_rsp: assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_valid) |-> !$past(req_ready))
      else $error("Response appeared without the request side being busy.");

endmodule

bind range_gcd_of_differences rgd_checker u_rgd_checker (
   .clock         (clock),
   .reset         (reset),
   .req_ready     (req_ready),
   .rsp_valid     (rsp_valid),
   .rsp_ready     (rsp_ready),
   .rsp_range_gcd (rsp_range_gcd),
   .rsp_bad_range (rsp_bad_range)
);

// ===== verif/tb.sv =====
`timescale 1ns / 100ps

module tb;
   import rgd_pkg::*;

   localparam int DEPTH = 1024;
   localparam int LEVELS = 11;

   class gcd_scoreboard;
      logic [31:0] prev_val;
      int          count;
      logic [31:0] sparse [LEVELS][DEPTH];
      logic [31:0] exp_gcd [$];
      logic        exp_bad [$];
      int          mismatches;

      function new();
         prev_val = '0;
         count = 0;
         mismatches = 0;
      endfunction

      function logic [31:0] gcd2(logic [31:0] a, logic [31:0] b);
         logic [31:0] t;
         while (b != 0) begin
            t = a % b;
            a = b;
            b = t;
         end
         return a;
      endfunction

      function logic [31:0] cell_at(int lvl, int pos);
         if (lvl >= LEVELS || pos >= DEPTH) return '0;
         return sparse[lvl][pos];
      endfunction

      function logic [31:0] diffs_gcd(int first, int len);
         int lg;
         int span;
         int pos;
         int stop;
         logic [31:0] g;
         lg = 0;
         while ((len >> (lg + 1)) != 0) lg++;
         if (lg < LEVELS) begin
            span = 1 << lg;
            return gcd2(cell_at(lg, first), cell_at(lg, first + len - span));
         end
         span = 1 << (LEVELS - 1);
         g = '0;
         pos = first;
         stop = first + len;
         while (pos + span <= stop) begin
            g = gcd2(g, cell_at(LEVELS - 1, pos));
            pos += span;
         end
         if (pos < stop) g = gcd2(g, cell_at(LEVELS - 1, stop - span));
         return g;
      endfunction

      function void note_request(logic [1:0] mode, logic [31:0] val, int lo, int hi);
         int d;
         int span;
         int st;
         if (mode == MODE_CLEAR) begin
            count = 0;
            prev_val = '0;
         end else if (mode == MODE_APPEND) begin
            if (count < DEPTH) begin
               if (count > 0) begin
                  d = count - 1;
                  sparse[0][d] = (val > prev_val) ? val - prev_val : prev_val - val;
                  for (int j = 1; j < LEVELS; j++) begin
                     span = 1 << j;
                     if (d + 1 < span) break;
                     st = d + 1 - span;
                     sparse[j][st] = gcd2(cell_at(j - 1, st), cell_at(j - 1, st + span / 2));
                  end
               end
               prev_val = val;
               count++;
            end
         end else if (mode == MODE_QUERY) begin
            if (hi < lo || hi >= count) begin
               exp_gcd.push_back('0);
               exp_bad.push_back(1'b1);
            end else begin
               exp_gcd.push_back(lo == hi ? 32'd0 : diffs_gcd(lo, hi - lo));
               exp_bad.push_back(1'b0);
            end
         end
      endfunction

      function void check_result(logic [31:0] g, logic bad);
         logic [31:0] eg;
         logic        eb;
         if (exp_gcd.size() == 0) begin
            mismatches++;
            if (mismatches <= 10) $display("Unexpected response: gcd %0d bad %0b", g, bad);
            return;
         end
         eg = exp_gcd.pop_front();
         eb = exp_bad.pop_front();
         if (g !== eg || bad !== eb) begin
            mismatches++;
            if (mismatches <= 10)
               $display("Mismatch: expected gcd %0d bad %0b, got gcd %0d bad %0b",
                        eg, eb, g, bad);
         end
      endfunction
   endclass

   logic        clock;
   logic        reset;
   logic        req_valid;
   logic        req_ready;
   logic [1:0]  req_mode;
   logic [31:0] req_value;
   logic [9:0]  req_left_index;
   logic [9:0]  req_right_index;
   logic        rsp_valid;
   logic        rsp_ready;
   logic [31:0] rsp_range_gcd;
   logic        rsp_bad_range;

   gcd_scoreboard sb;
   bit            stim_done;
   bit            hold_rsp;
   int            shadow_count;
   logic [31:0]   base_val;
   logic [31:0]   step_val;

   range_gcd_of_differences dut (.*);

   initial begin
      clock = 1'b0;
      forever #1 clock = ~clock;
   end

   initial begin
      #50ms;
      $display("TB_ERROR");
      $finish;
   end

   always @(posedge clock) begin
      if (!reset && req_valid && req_ready)
         sb.note_request(req_mode, req_value, req_left_index, req_right_index);
      if (!reset && rsp_valid && rsp_ready)
         sb.check_result(rsp_range_gcd, rsp_bad_range);
   end

   initial begin
      int ph;
      rsp_ready = 1'b0;
      @(negedge clock);
      while (!stim_done || sb.exp_gcd.size() != 0) begin
         ph = $urandom_range(0, 7);
         if (hold_rsp) begin
            rsp_ready <= 1'b0;
            repeat (3000) @(negedge clock);
            hold_rsp = 1'b0;
         end
         rsp_ready <= (ph < 5) || ph[0];
         @(negedge clock);
         if (ph == 7) repeat ($urandom_range(0, 20)) @(negedge clock);
      end
      rsp_ready <= 1'b1;
   end

   task automatic send(logic [1:0] mode, logic [31:0] val, int lo, int hi);
      req_valid <= 1'b1;
      req_mode <= mode;
      req_value <= val;
      req_left_index <= lo[9:0];
      req_right_index <= hi[9:0];
      @(posedge clock);
      while (!req_ready) @(posedge clock);
      @(negedge clock);
      if (mode == MODE_CLEAR) shadow_count = 0;
      else if (mode == MODE_APPEND && shadow_count < DEPTH) shadow_count++;
      if ($urandom_range(0, 9) == 0) begin
         req_valid <= 1'b0;
         repeat ($urandom_range(1, 30)) @(negedge clock);
      end
   endtask

   task automatic random_item();
      int r;
      int lo;
      int hi;
      r = $urandom_range(0, 99);
      if (r < 2) send(MODE_CLEAR, $urandom, $urandom, $urandom);
      else if (r < 3) send(MODE_UNUSED, $urandom, $urandom, $urandom);
      else if (r < 45) begin
         if ($urandom_range(0, 2) == 0) send(MODE_APPEND, $urandom, 0, 0);
         else send(MODE_APPEND, base_val + step_val * $urandom_range(0, 50), 0, 0);
      end else if (r < 52) send(MODE_QUERY, 0, $urandom, $urandom);
      else if (shadow_count > 0) begin
         hi = $urandom_range(0, shadow_count - 1);
         lo = $urandom_range(0, hi);
         send(MODE_QUERY, 0, lo, hi);
      end else send(MODE_QUERY, 0, 0, 0);
   endtask

   initial begin
      sb = new();
      stim_done = 1'b0;
      hold_rsp = 1'b0;
      shadow_count = 0;
      reset = 1'b1;
      req_valid = 1'b0;
      req_mode = MODE_CLEAR;
      req_value = '0;
      req_left_index = '0;
      req_right_index = '0;
      repeat (4) @(negedge clock);
      reset = 1'b0;

      send(MODE_QUERY, 0, 0, 0);
      send(MODE_APPEND, 32'hFFFF_FFFF, 0, 0);
      send(MODE_QUERY, 0, 0, 0);
      send(MODE_APPEND, 32'd0, 0, 0);
      send(MODE_APPEND, 32'd12, 0, 0);
      send(MODE_APPEND, 32'd30, 0, 0);
      send(MODE_QUERY, 0, 0, 3);
      send(MODE_QUERY, 0, 1, 3);
      send(MODE_QUERY, 0, 2, 2);
      send(MODE_QUERY, 0, 3, 1);
      send(MODE_QUERY, 0, 0, 4);
      send(MODE_QUERY, 0, 1023, 1023);
      send(MODE_UNUSED, 32'hFFFF_FFFF, 1023, 1023);
      send(MODE_QUERY, 0, 0, 3);
      send(MODE_CLEAR, 0, 0, 0);
      send(MODE_QUERY, 0, 0, 0);
      for (int i = 0; i < DEPTH + 2; i++)
         send(MODE_APPEND, 32'd7 + 32'd21 * i[31:0] + (i == 700 ? 32'd7 : 32'd0), 0, 0);
      send(MODE_QUERY, 0, 0, 1023);
      send(MODE_QUERY, 0, 1, 1023);
      send(MODE_QUERY, 0, 0, 699);
      send(MODE_QUERY, 0, 5, 1030);
      hold_rsp = 1'b1;
      for (int i = 0; i < 6; i++) send(MODE_QUERY, 0, i, 1000 - i);
      send(MODE_CLEAR, 0, 0, 0);

      for (int n = 0; n < 300; n++) begin
         if (n % 150 == 0) begin
            base_val = $urandom;
            step_val = 32'd1 << $urandom_range(0, 12);
            step_val = step_val * $urandom_range(1, 9);
         end
         random_item();
      end
      req_valid <= 1'b0;
      stim_done = 1'b1;
      while (sb.exp_gcd.size() != 0) @(negedge clock);
      repeat (2000) @(negedge clock);
      if (sb.mismatches == 0 && sb.exp_gcd.size() == 0) $display("TB_OK");
      else $display("TB_ERROR");
      $finish;
   end
endmodule

// ===== range_gcd_of_differences.f =====
rtl/core/rgd_pkg.sv
rtl/core/rgd_ram.sv
rtl/core/rgd_gcd.sv
rtl/core/rgd_datapath.sv
rtl/core/rgd_ctrl.sv
rtl/core/range_gcd_of_differences.sv
rtl/core/rgd_checker.sv
verif/tb.sv
